/* hdl/enms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

    // Gradient and magnitude widths follow from the fixed 16-bit payload fields.
    localparam int GRAD_BITS  = 16;
    localparam int MAG_BITS   = 2 * GRAD_BITS;
    localparam int SLOPE_BITS = GRAD_BITS + 16;

    localparam int IMAGE_SIZE_DEF = 256;
    localparam int PIXEL_BITS     = 8;

    localparam int MARGIN_BITS = 6;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 6'd3;

    // Slope thresholds tan(22.5) and tan(67.5), scaled by SLOPE_SCALE.
    localparam int TAN_LOW_X10K  = 4142;
    localparam int TAN_HIGH_X10K = 24142;
    localparam int SLOPE_SCALE   = 10000;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    typedef enum logic [1:0] {
        SEC_HORZ,
        SEC_DIAG_RISE,
        SEC_DIAG_FALL,
        SEC_VERT
    } t_sector;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic                        frame_start;
    } t_pixel;

    typedef struct packed {
        logic                  peak;
        logic [PIXEL_BITS-1:0] pixel_row;
        logic [PIXEL_BITS-1:0] pixel_col;
    } t_flag;

    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
    } t_front_busy;

endpackage

`default_nettype wire

/* hdl/enms_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module enms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic      [LW-1:0]    o_level
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [LW-1:0]    r_level;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [LW-1:0]    n_level;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        n_level  = r_level + LW'(i_push) - LW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_level != LW'(DEPTH)))
        else $error("Queue written while holding DEPTH items.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Queue read while empty.");
`endif

endmodule

`default_nettype wire

/* hdl/enms_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module enms_front
    import enms_pkg::*;
#(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF,
    localparam int PW = $clog2(IMAGE_SIZE)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire t_pixel              i_pixel,
    output logic                     o_push,
    output logic      [MAG_BITS-1:0] o_mag,
    output t_sector                  o_sector,
    output logic      [PW-1:0]       o_row,
    output logic      [PW-1:0]       o_col,
    output t_front_busy              o_busy
);

    localparam logic [PW-1:0] LAST_POS = PW'(IMAGE_SIZE - 1);
    localparam logic signed [SLOPE_BITS-1:0] SCALE_S  = SLOPE_BITS'(SLOPE_SCALE);
    localparam logic signed [SLOPE_BITS-1:0] TAN_LO_S = SLOPE_BITS'(TAN_LOW_X10K);
    localparam logic signed [SLOPE_BITS-1:0] TAN_HI_S = SLOPE_BITS'(TAN_HIGH_X10K);

    // Position counters for the next incoming pixel.
    logic [PW-1:0] r_row_cnt;
    logic [PW-1:0] r_col_cnt;
    logic [PW-1:0] n_row_cnt;
    logic [PW-1:0] n_col_cnt;
    logic [PW-1:0] cur_row;
    logic [PW-1:0] cur_col;

    logic signed [GRAD_BITS:0] gx_e;
    logic signed [GRAD_BITS:0] gy_e;
    logic signed [GRAD_BITS:0] abs_x;
    logic signed [GRAD_BITS:0] abs_y;
    logic signed [GRAD_BITS:0] num;
    logic [GRAD_BITS-1:0]      den;
    logic [GRAD_BITS-1:0]      mag_y;

    logic [MAG_BITS-1:0]          n_s1_sq_x;
    logic [MAG_BITS-1:0]          n_s1_sq_y;
    logic signed [SLOPE_BITS-1:0] n_s1_slope;
    logic signed [SLOPE_BITS-1:0] n_s1_lim_lo;
    logic signed [SLOPE_BITS-1:0] n_s1_lim_hi;

    // Stage 1: products.
    logic                         r_s1_valid;
    logic [MAG_BITS-1:0]          r_s1_sq_x;
    logic [MAG_BITS-1:0]          r_s1_sq_y;
    logic signed [SLOPE_BITS-1:0] r_s1_slope;
    logic signed [SLOPE_BITS-1:0] r_s1_lim_lo;
    logic signed [SLOPE_BITS-1:0] r_s1_lim_hi;
    logic                         r_s1_gx_zero;
    logic                         r_s1_gy_zero;
    logic [PW-1:0]                r_s1_row;
    logic [PW-1:0]                r_s1_col;

    logic signed [SLOPE_BITS-1:0] neg_lo;
    logic signed [SLOPE_BITS-1:0] neg_hi;
    logic [MAG_BITS-1:0]          n_s2_mag;
    t_sector                      n_s2_sector;

    // Stage 2: magnitude and sector.
    logic                r_s2_valid;
    logic [MAG_BITS-1:0] r_s2_mag;
    t_sector             r_s2_sector;
    logic [PW-1:0]       r_s2_row;
    logic [PW-1:0]       r_s2_col;

    always_comb begin
        cur_row = i_pixel.frame_start ? '0 : r_row_cnt;
        cur_col = i_pixel.frame_start ? '0 : r_col_cnt;
        if (cur_col == LAST_POS) begin
            n_col_cnt = '0;
            n_row_cnt = (cur_row == LAST_POS) ? '0 : cur_row + 1'b1;
        end else begin
            n_col_cnt = cur_col + 1'b1;
            n_row_cnt = cur_row;
        end
    end

    // The slope is folded so that the denominator is never negative.
    always_comb begin
        gx_e  = $signed({i_pixel.grad_x[GRAD_BITS-1], i_pixel.grad_x});
        gy_e  = $signed({i_pixel.grad_y[GRAD_BITS-1], i_pixel.grad_y});
        abs_x = gx_e[GRAD_BITS] ? -gx_e : gx_e;
        abs_y = gy_e[GRAD_BITS] ? -gy_e : gy_e;
        num   = gx_e[GRAD_BITS] ? -gy_e : gy_e;
        den   = abs_x[GRAD_BITS-1:0];
        mag_y = abs_y[GRAD_BITS-1:0];

        n_s1_sq_x   = MAG_BITS'(den) * MAG_BITS'(den);
        n_s1_sq_y   = MAG_BITS'(mag_y) * MAG_BITS'(mag_y);
        n_s1_slope  = SLOPE_BITS'(num) * SCALE_S;
        n_s1_lim_lo = SLOPE_BITS'($signed({1'b0, den})) * TAN_LO_S;
        n_s1_lim_hi = SLOPE_BITS'($signed({1'b0, den})) * TAN_HI_S;
    end

    always_comb begin
        neg_lo   = -r_s1_lim_lo;
        neg_hi   = -r_s1_lim_hi;
        n_s2_mag = r_s1_sq_x + r_s1_sq_y;
        if (r_s1_gx_zero) begin
            n_s2_sector = r_s1_gy_zero ? SEC_HORZ : SEC_VERT;
        end else if (r_s1_slope <= r_s1_lim_lo && r_s1_slope > neg_lo) begin
            n_s2_sector = SEC_HORZ;
        end else if (r_s1_slope <= r_s1_lim_hi && r_s1_slope > r_s1_lim_lo) begin
            n_s2_sector = SEC_DIAG_RISE;
        end else if (r_s1_slope <= neg_lo && r_s1_slope > neg_hi) begin
            n_s2_sector = SEC_DIAG_FALL;
        end else begin
            n_s2_sector = SEC_VERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_row_cnt <= n_row_cnt;
                r_col_cnt <= n_col_cnt;
            end
            r_s1_valid <= i_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sq_x    <= n_s1_sq_x;
        r_s1_sq_y    <= n_s1_sq_y;
        r_s1_slope   <= n_s1_slope;
        r_s1_lim_lo  <= n_s1_lim_lo;
        r_s1_lim_hi  <= n_s1_lim_hi;
        r_s1_gx_zero <= (i_pixel.grad_x == '0);
        r_s1_gy_zero <= (i_pixel.grad_y == '0);
        r_s1_row     <= cur_row;
        r_s1_col     <= cur_col;
        r_s2_mag     <= n_s2_mag;
        r_s2_sector  <= n_s2_sector;
        r_s2_row     <= r_s1_row;
        r_s2_col     <= r_s1_col;
    end

    assign o_push          = r_s2_valid;
    assign o_mag           = r_s2_mag;
    assign o_sector        = r_s2_sector;
    assign o_row           = r_s2_row;
    assign o_col           = r_s2_col;
    assign o_busy.s1_busy  = r_s1_valid;
    assign o_busy.s2_busy  = r_s2_valid;

endmodule

`default_nettype wire

/* hdl/enms_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module enms_back
    import enms_pkg::*;
#(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF,
    localparam int PW  = $clog2(IMAGE_SIZE),
    localparam int OLW = $clog2(OUT_DEPTH + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire logic [MAG_BITS-1:0]    i_mag,
    input  wire t_sector                i_sector,
    input  wire logic [PW-1:0]          i_row,
    input  wire logic [PW-1:0]          i_col,
    input  wire logic [OLW-1:0]         i_out_level,
    input  wire logic [MARGIN_BITS-1:0] i_margin,
    output logic                        o_pop,
    output logic                        o_push,
    output t_flag                       o_flag
);

    localparam int IW = ((PW > MARGIN_BITS) ? PW : MARGIN_BITS) + 1;
    localparam int XW = (PW > PIXEL_BITS) ? PW : PIXEL_BITS;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag_two_back;
        logic [MAG_BITS-1:0] mag_one_back;
        t_sector             sector_one_back;
    } t_line_entry;

    // Two magnitude rows and one sector row, all indexed by column.
    t_line_entry r_line_mem [IMAGE_SIZE];
    t_line_entry r_line_rd;
    t_line_entry n_line_wr;

    logic                r_valid;
    logic [MAG_BITS-1:0] r_mag;
    t_sector             r_sector;
    logic [PW-1:0]       r_row;
    logic [PW-1:0]       r_col;

    // Columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom.
    logic [MAG_BITS-1:0] r_win [6];
    t_sector             r_center_sec;

    logic [MAG_BITS-1:0]    top;
    logic [MAG_BITS-1:0]    mid;
    logic [MAG_BITS-1:0]    bot;
    logic [MAG_BITS-1:0]    nb_a;
    logic [MAG_BITS-1:0]    nb_b;
    logic [PW-1:0]          prev_row;
    logic [PW-1:0]          prev_col;
    logic [XW-1:0]          row_x;
    logic [XW-1:0]          col_x;
    logic [MARGIN_BITS-1:0] margin;
    logic                   peak;

    function automatic logic in_core(input logic [PW-1:0] pos,
                                     input logic [MARGIN_BITS-1:0] m);
        logic [IW-1:0] p;
        logic [IW-1:0] w;
        p = IW'(pos);
        w = IW'(m);
        return (p >= w) && ((p + w) < IW'(IMAGE_SIZE));
    endfunction

    assign o_pop = !i_empty &&
                   ((OLW + 1)'(i_out_level) + (OLW + 1)'(r_valid) < (OLW + 1)'(OUT_DEPTH));

    always_comb begin
        top = r_line_rd.mag_two_back;
        mid = r_line_rd.mag_one_back;
        bot = r_mag;
        case (r_center_sec)
            SEC_HORZ: begin
                nb_a = r_win[1];
                nb_b = mid;
            end
            SEC_DIAG_RISE: begin
                nb_a = r_win[0];
                nb_b = bot;
            end
            SEC_DIAG_FALL: begin
                nb_a = r_win[2];
                nb_b = top;
            end
            default: begin
                nb_a = r_win[3];
                nb_b = r_win[5];
            end
        endcase

        prev_row = r_row - 1'b1;
        prev_col = r_col - 1'b1;
        row_x    = XW'(prev_row);
        col_x    = XW'(prev_col);
        margin   = (i_margin == '0) ? MARGIN_BITS'(1) : i_margin;
        peak     = in_core(prev_row, margin) && in_core(prev_col, margin) &&
                   (r_win[4] > nb_a) && (r_win[4] > nb_b);

        n_line_wr.mag_two_back    = mid;
        n_line_wr.mag_one_back    = r_mag;
        n_line_wr.sector_one_back = r_sector;
    end

    assign o_push           = r_valid && (r_row != '0) && (r_col != '0);
    assign o_flag.peak      = peak;
    assign o_flag.pixel_row = row_x[PIXEL_BITS-1:0];
    assign o_flag.pixel_col = col_x[PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_line_mem[r_col] <= n_line_wr;
        end
        if (o_pop) begin
            r_line_rd <= r_line_mem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_center_sec <= SEC_HORZ;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_valid <= o_pop;
            if (r_valid) begin
                r_center_sec <= r_line_rd.sector_one_back;
                r_win[0]     <= r_win[3];
                r_win[1]     <= r_win[4];
                r_win[2]     <= r_win[5];
                r_win[3]     <= top;
                r_win[4]     <= mid;
                r_win[5]     <= bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag    <= i_mag;
            r_sector <= i_sector;
            r_row    <= i_row;
            r_col    <= i_col;
        end
    end

endmodule

`default_nettype wire

/* hdl/edge_non_maximum_suppression_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Canny non-maximum suppression on a raster stream of pixel gradients. Each
// item pushed in is the horizontal and vertical gradient of one pixel of an
// IMAGE_SIZE x IMAGE_SIZE image in raster order, with frame_start marking the
// first pixel of a frame. Each item popped out is a peak flag together with
// the row and column of the pixel it belongs to; the flag for pixel (r, c) is
// produced by the arrival of pixel (r+1, c+1), so the first row and column of
// input yield no result. The block takes one item per clock and sustains that
// rate for as long as results are popped; the limit is the line buffer in the
// back end, which reads one column and writes one column per clock. A result
// passes from the accepting edge, which loads the multiply stage, through the
// classify stage, the middle queue, the window stage and the output queue,
// from which it can be popped; it waits in the middle queue while the output
// queue has no room. The user must write border_margin through
// i_cfg_we/i_cfg_wdata only while the block is idle, which is not enforced;
// a margin of zero acts as a margin of one. The line buffers have no reset,
// which is safe because stale entries only ever reach pixels in the border.

module edge_non_maximum_suppression_core
    import enms_pkg::*;
#(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire t_pixel                 i_pixel,
    output logic                        empty,
    input  wire logic                   pop,
    output t_flag                       o_flag,
    input  wire logic                   i_cfg_we,
    input  wire logic [MARGIN_BITS-1:0] i_cfg_wdata
);

    localparam int PW  = $clog2(IMAGE_SIZE);
    localparam int MQW = MAG_BITS + $bits(t_sector) + 2 * PW;
    localparam int MLW = $clog2(MID_DEPTH + 1);
    localparam int OLW = $clog2(OUT_DEPTH + 1);
    localparam int MCW = $clog2(MID_DEPTH + 3);
    localparam int FW  = $bits(t_flag);

    logic [MARGIN_BITS-1:0] r_border_margin;

    logic                accept;
    logic                fe_push;
    logic [MAG_BITS-1:0] fe_mag;
    t_sector             fe_sector;
    logic [PW-1:0]       fe_row;
    logic [PW-1:0]       fe_col;
    t_front_busy         fe_busy;

    logic [MQW-1:0] mid_head;
    logic           mid_empty;
    logic [MLW-1:0] mid_level;
    logic [MCW-1:0] mid_credit;

    logic           be_pop;
    logic           be_push;
    t_flag          be_flag;
    logic [FW-1:0]  out_head;
    logic [OLW-1:0] out_level;

    // Users write the configuration register only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            r_border_margin <= i_cfg_wdata;
        end
    end

    // The front end never stalls once an item is inside, so the middle queue
    // must keep room for every item still in flight in the front stages.
    // The item count plus those in flight is compared against the depth.
    assign mid_credit = MCW'(mid_level) + MCW'(fe_busy.s1_busy) + MCW'(fe_busy.s2_busy);
    assign full       = (mid_credit >= MCW'(MID_DEPTH));
    assign accept     = push && !full;

    // Front end: position counters, squared magnitude and sector.
    enms_front #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pixel  (i_pixel),
        .o_push   (fe_push),
        .o_mag    (fe_mag),
        .o_sector (fe_sector),
        .o_row    (fe_row),
        .o_col    (fe_col),
        .o_busy   (fe_busy)
    );

    // Short queue between the classifier and the window stage.
    enms_queue #(
        .WIDTH (MQW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_mag, fe_sector, fe_row, fe_col}),
        .i_pop   (be_pop),
        .o_data  (mid_head),
        .o_empty (mid_empty),
        .o_level (mid_level)
    );

    // Back end: line buffers, 3x3 window and the peak decision. It pulls an
    // item from the middle queue only when the output queue has room for it.
    enms_back #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (mid_empty),
        .i_mag       (mid_head[MQW-1 -: MAG_BITS]),
        .i_sector    (t_sector'(mid_head[2 * PW +: $bits(t_sector)])),
        .i_row       (mid_head[PW +: PW]),
        .i_col       (mid_head[0 +: PW]),
        .i_out_level (out_level),
        .i_margin    (r_border_margin),
        .o_pop       (be_pop),
        .o_push      (be_push),
        .o_flag      (be_flag)
    );

    // Output queue; it decouples the result side from the window stage.
    enms_queue #(
        .WIDTH (FW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push),
        .i_data  (be_flag),
        .i_pop   (pop && !empty),
        .o_data  (out_head),
        .o_empty (empty),
        .o_level (out_level)
    );

    assign o_flag = t_flag'(out_head);

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_credit <= MCW'(MID_DEPTH))
        else $error("Middle queue items plus front-end items exceed its depth.");
`endif

endmodule

`default_nettype wire

/* tb/peak_flag_checker.sv */
`timescale 1ns / 1ps

// Watches both queues of the suppression core, keeps its own copy of the
// line buffers and the 3x3 window, and compares every popped flag with the
// oldest prediction.
module peak_flag_checker
    import enms_pkg::*;
#(
    parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_full,
    input  t_pixel                 i_pixel,
    input  logic                   i_empty,
    input  logic                   i_pop,
    input  t_flag                  i_flag,
    input  logic                   i_cfg_we,
    input  logic [MARGIN_BITS-1:0] i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    logic [MAG_BITS-1:0]    mag_two_back    [IMAGE_SIZE];
    logic [MAG_BITS-1:0]    mag_one_back    [IMAGE_SIZE];
    t_sector                sector_one_back [IMAGE_SIZE];
    logic [MAG_BITS-1:0]    window [6];
    t_sector                centre_sector;
    int unsigned            row_pos;
    int unsigned            col_pos;
    logic [MARGIN_BITS-1:0] margin;
    t_flag                  queued_peak_flags [$];

    function automatic bit in_interior(input int unsigned pos, input int unsigned m);
        return pos >= m && pos + m < IMAGE_SIZE;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : predict_and_compare
        longint              gx, gy, ax, ay, num, lo, hi;
        logic [MAG_BITS-1:0] mag, top, mid, bot, centre, n1, n2;
        t_sector             sec;
        int unsigned         r, c, m;
        t_flag               want;

        if (!i_rst_n) begin
            foreach (mag_two_back[k]) begin
                mag_two_back[k]    = '0;
                mag_one_back[k]    = '0;
                sector_one_back[k] = SEC_HORZ;
            end
            foreach (window[k]) begin
                window[k] = '0;
            end
            centre_sector = SEC_HORZ;
            row_pos       = 0;
            col_pos       = 0;
            margin        = MARGIN_RESET;
            queued_peak_flags.delete();
        end else begin
            if (i_cfg_we) begin
                margin = i_cfg_wdata;
            end

            // A result popped on this edge can never belong to an item pushed on it.
            if (i_pop && !i_empty) begin
                if (queued_peak_flags.size() == 0) begin
                    $display("%0d ns: flag mismatch, expected none, actual peak %0b row %0d col %0d",
                             $time, i_flag.peak, i_flag.pixel_row, i_flag.pixel_col);
                    o_fail_count++;
                end else begin
                    want = queued_peak_flags.pop_front();
                    report_field("peak", 8'(want.peak), 8'(i_flag.peak));
                    report_field("pixel_row", want.pixel_row, i_flag.pixel_row);
                    report_field("pixel_col", want.pixel_col, i_flag.pixel_col);
                end
            end

            if (i_push && !i_full) begin
                gx = i_pixel.grad_x;
                gy = i_pixel.grad_y;
                if (i_pixel.frame_start) begin
                    row_pos = 0;
                    col_pos = 0;
                end
                r   = row_pos;
                c   = col_pos;
                ax  = (gx < 0) ? -gx : gx;
                ay  = (gy < 0) ? -gy : gy;
                mag = MAG_BITS'(ax * ax + ay * ay);

                // Zero horizontal gradient is treated as a tiny positive one.
                if (gx == 0) begin
                    sec = (gy == 0) ? SEC_HORZ : SEC_VERT;
                end else begin
                    num = ((gx < 0) ? -gy : gy) * SLOPE_SCALE;
                    lo  = TAN_LOW_X10K * ax;
                    hi  = TAN_HIGH_X10K * ax;
                    if (num <= lo && num > -lo) begin
                        sec = SEC_HORZ;
                    end else if (num <= hi && num > lo) begin
                        sec = SEC_DIAG_RISE;
                    end else if (num <= -lo && num > -hi) begin
                        sec = SEC_DIAG_FALL;
                    end else begin
                        sec = SEC_VERT;
                    end
                end

                top = mag_two_back[c];
                mid = mag_one_back[c];
                bot = mag;

                if (r >= 1 && c >= 1) begin
                    m      = (margin == 0) ? 1 : margin;
                    centre = window[4];
                    case (centre_sector)
                        SEC_HORZ: begin
                            n1 = window[1];
                            n2 = mid;
                        end
                        SEC_DIAG_RISE: begin
                            n1 = window[0];
                            n2 = bot;
                        end
                        SEC_DIAG_FALL: begin
                            n1 = window[2];
                            n2 = top;
                        end
                        default: begin
                            n1 = window[3];
                            n2 = window[5];
                        end
                    endcase
                    want.peak = in_interior(r - 1, m) && in_interior(c - 1, m) &&
                                centre > n1 && centre > n2;
                    want.pixel_row = 8'(r - 1);
                    want.pixel_col = 8'(c - 1);
                    queued_peak_flags.push_back(want);
                end

                centre_sector      = sector_one_back[c];
                sector_one_back[c] = sec;
                mag_two_back[c]    = mid;
                mag_one_back[c]    = mag;
                window[0]          = window[3];
                window[1]          = window[4];
                window[2]          = window[5];
                window[3]          = top;
                window[4]          = mid;
                window[5]          = bot;

                col_pos = c + 1;
                if (col_pos >= IMAGE_SIZE) begin
                    col_pos = 0;
                    row_pos = r + 1;
                    if (row_pos >= IMAGE_SIZE) begin
                        row_pos = 0;
                    end
                end
            end
        end
        o_pending = queued_peak_flags.size();
    end

endmodule

/* tb/edge_non_maximum_suppression_core_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the suppression core. The checker beside the block
// does all prediction and comparison; this module only feeds gradient items,
// drains flags, rewrites the border margin between phases, and watches for a
// stalled run.
module edge_non_maximum_suppression_core_tb;
    import enms_pkg::*;

    // The longest deliberate pop hold-off, and the watchdog limit built on it.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 2000;
    // Cycles to wait after the last flag so that trailing items, which make no
    // flag of their own, have left the front stages and the window stage.
    localparam int DRAIN_CYCLES    = 12;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    t_pixel                 i_pixel     = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    t_flag                  o_flag;
    logic                   i_cfg_we    = 1'b0;
    logic [MARGIN_BITS-1:0] i_cfg_wdata = '0;

    int fail_count;
    int pending;

    // Random idle bursts are allowed on both sides while this is set.
    bit idle_on      = 1'b1;
    // Raised once by the stimulus to make the receiver hold off for a long time.
    bit hold_pending = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    edge_non_maximum_suppression_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_flag      (o_flag),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    peak_flag_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_pixel      (i_pixel),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_flag       (o_flag),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gradient values at the edges of the signed range and next to zero.
    function automatic logic signed [GRAD_BITS-1:0] extreme_value();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    // Offers one item starting at a falling edge, possibly after an idle burst,
    // and returns at the falling edge after the item was taken. push is left
    // high so that back-to-back items need no extra assignment.
    task automatic send_pixel(input t_pixel px);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= px;
        do begin
            @(posedge i_clk);
        end while (full);
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every predicted flag has been
    // popped and the pipeline has emptied behind it.
    task automatic drain();
        push <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The margin register may only change while the block is idle.
    task automatic set_margin(input logic [MARGIN_BITS-1:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Sends a stretch of random pixels in raster order. Every 32 items the
    // texture may switch to small gradients so that equal magnitudes, which
    // must not count as peaks, show up between neighbours. A rare stray
    // frame start restarts the counters in mid-frame.
    task automatic run_frame(input int unsigned count, input bit restart, input int hold_at);
        t_pixel      px;
        bit          calm;
        int unsigned mode;
        int unsigned k;

        calm = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (i == hold_at) begin
                hold_pending = 1'b1;
            end
            mode = (calm && $urandom_range(0, 4) != 0) ? 50 : $urandom_range(0, 99);
            if (mode < 45) begin
                px.grad_x = 16'($urandom);
                px.grad_y = 16'($urandom);
            end else if (mode < 65) begin
                px.grad_x = 16'($urandom_range(0, 6)) - 16'd3;
                px.grad_y = 16'($urandom_range(0, 6)) - 16'd3;
            end else if (mode < 80) begin
                px.grad_x = extreme_value();
                px.grad_y = extreme_value();
            end else if (mode < 90) begin
                // Slopes on and one step off the 22.5 and 67.5 degree tangents.
                k         = $urandom_range(1, 2);
                px.grad_x = 16'(5000 * k);
                px.grad_y = 16'(($urandom_range(0, 1) ? 12071 : 2071) * k +
                                $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1)) begin
                    px.grad_x = -px.grad_x;
                end
                if ($urandom_range(0, 1)) begin
                    px.grad_y = -px.grad_y;
                end
            end else begin
                // Vertical-only gradients, and the all-zero pixel.
                px.grad_x = '0;
                px.grad_y = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            end
            px.frame_start = (restart && i == 0) || ($urandom_range(0, 399) == 0);
            send_pixel(px);
        end
    endtask

    initial begin : stimulus
        int          dir_x [24];
        int          dir_y [24];
        t_pixel      px;
        int unsigned wide;

        dir_x = '{0, 0, 0, 32767, -32768, -32768, 32767, 0, -32768,
                  5000, 5000, 5000, 5000, 5000, 5000, 5000, 5000,
                  -5000, -5000, -5000, 10000, 10000, 1, -1};
        dir_y = '{0, 5, -5, 32767, -32768, 32767, -32768, -32768, 0,
                  2071, 2072, 12071, 12072, -2071, -2070, -12071, -12070,
                  2071, -2071, 12071, 24142, 24143, 0, 0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items open the first frame under the reset margin: a zero
        // gradient, zero horizontal gradients, the corners of the signed range,
        // and slopes exactly on and just past both sector tangents.
        for (int i = 0; i < 24; i++) begin
            px.grad_x      = 16'(dir_x[i]);
            px.grad_y      = 16'(dir_y[i]);
            px.frame_start = (i == 0);
            send_pixel(px);
        end
        run_frame(276, 1'b0, -1);

        // The frame carries on across the margin changes below. A margin of
        // one lets the second row be flagged. The long pop hold-off happens
        // here, so the output queue fills and full rises.
        set_margin(6'd1);
        run_frame(IMAGE_SIZE_DEF + 144, 1'b0, 100);

        // Widest margin: nothing inside the few rows reached may be flagged.
        set_margin(6'd63);
        run_frame(200, 1'b0, -1);

        // A margin of zero must behave as a margin of one.
        set_margin(6'd0);
        run_frame(200, 1'b0, -1);

        wide = $urandom_range(2, 4);
        set_margin(MARGIN_BITS'(wide));
        run_frame(200, 1'b0, -1);

        // The closing stretch starts a new frame and runs with both sides
        // always ready.
        set_margin(6'd1);
        idle_on = 1'b0;
        run_frame(200, 1'b1, -1);
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Pops at random with idle bursts, and once holds off for a long time,
    // counted here, while the sender keeps offering items.
    initial begin : receiver
        bit held;

        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_pending && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Ends the run if neither queue moves for too long.
    initial begin : watchdog
        int unsigned quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule
